// ===== hw/rtl/led_matrix_text_frame_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// led matrix text frame encoder assertion macros
// shared concurrent assertion forms, clocked on clock, held off by reset
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_TEXT_FRAME_ENCODER_MACROS_SVH
`define LED_MATRIX_TEXT_FRAME_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define LMTFE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lmtfe property violated");
// condition must never be seen outside reset
`define LMTFE_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("lmtfe forbidden condition seen");
`else
`define LMTFE_ASSERT(lbl, prop)
`define LMTFE_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/lmtfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtfe_pkg
// shared types, constants, font table and decimal place table
// ----------------------------------------------------------------------------
package lmtfe_pkg;

   localparam int ReqDataW   = 112;
   localparam int RspDataW   = 16;
   localparam int TextFields = 5;
   localparam int FrameCols  = 32;
   localparam int DecPlaces  = 19;

   // glyph indexes of the non-digit symbols
   localparam logic [3:0] GlyphDash  = 4'd10;
   localparam logic [3:0] GlyphDot   = 4'd11;
   localparam logic [3:0] GlyphKilo  = 4'd12;
   localparam logic [3:0] GlyphMega  = 4'd13;
   localparam logic [3:0] GlyphBil   = 4'd14;
   localparam logic [3:0] GlyphBlank = 4'd15;

   // register addresses and config indexes
   localparam logic [3:0] RegIntensity   = 4'd10;
   localparam logic [7:0] CsrModuleCount = 8'd0;
   localparam logic [7:0] CsrStartBright = 8'd1;

   typedef logic [4:0][7:0]  glyph_type;
   typedef logic [7:0][31:0] frame_type;
   typedef logic [TextFields-1:0][3:0] glyph_row_type;

   typedef struct packed {
      logic          done;
      logic [4:0]    count;
      glyph_row_type digits;
   } digit_res_type;

   typedef struct packed {
      logic [3:0] bright;
      logic [2:0] mods;
   } emit_job_type;

   // ascii code to glyph index, unknown codes draw blank
   function automatic logic [3:0] glyph_index(input logic [7:0] code);
      logic [3:0] g;
      unique case (code)
         8'h30: g = 4'd0;
         8'h31: g = 4'd1;
         8'h32: g = 4'd2;
         8'h33: g = 4'd3;
         8'h34: g = 4'd4;
         8'h35: g = 4'd5;
         8'h36: g = 4'd6;
         8'h37: g = 4'd7;
         8'h38: g = 4'd8;
         8'h39: g = 4'd9;
         8'h2D: g = GlyphDash;
         8'h2E: g = GlyphDot;
         8'h6B: g = GlyphKilo;
         8'h4D: g = GlyphMega;
         8'h42: g = GlyphBil;
         default: g = GlyphBlank;
      endcase
      return g;
   endfunction

   // font columns, element 0 is the leftmost column, bit 0 the top row
   function automatic glyph_type glyph_cols(input logic [3:0] idx);
      glyph_type c;
      unique case (idx)
         4'd0:  c = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         4'd1:  c = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         4'd2:  c = {8'h46, 8'h49, 8'h49, 8'h49, 8'h72};
         4'd3:  c = {8'h31, 8'h4B, 8'h4D, 8'h41, 8'h21};
         4'd4:  c = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         4'd5:  c = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         4'd6:  c = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         4'd7:  c = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         4'd8:  c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         4'd9:  c = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         4'd10: c = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         4'd11: c = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
         4'd12: c = {8'h00, 8'h44, 8'h28, 8'h10, 8'h7F};
         4'd13: c = {8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F};
         4'd14: c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
         default: c = '0;
      endcase
      return c;
   endfunction

   // left column of centred text of the given length
   function automatic logic [4:0] text_x0(input logic [2:0] len);
      logic [4:0] x;
      unique case (len)
         3'd1: x = 5'd13;
         3'd2: x = 5'd10;
         3'd3: x = 5'd7;
         3'd4: x = 5'd4;
         3'd5: x = 5'd1;
         default: x = 5'd0;
      endcase
      return x;
   endfunction

   // power of ten of a decimal place
   function automatic logic [62:0] pow10(input logic [4:0] place);
      logic [62:0] p;
      unique case (place)
         5'd0:  p = 63'd1;
         5'd1:  p = 63'd10;
         5'd2:  p = 63'd100;
         5'd3:  p = 63'd1000;
         5'd4:  p = 63'd10000;
         5'd5:  p = 63'd100000;
         5'd6:  p = 63'd1000000;
         5'd7:  p = 63'd10000000;
         5'd8:  p = 63'd100000000;
         5'd9:  p = 63'd1000000000;
         5'd10: p = 63'd10000000000;
         5'd11: p = 63'd100000000000;
         5'd12: p = 63'd1000000000000;
         5'd13: p = 63'd10000000000000;
         5'd14: p = 63'd100000000000000;
         5'd15: p = 63'd1000000000000000;
         5'd16: p = 63'd10000000000000000;
         5'd17: p = 63'd100000000000000000;
         5'd18: p = 63'd1000000000000000000;
         default: p = 63'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== hw/rtl/lmtfe_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtfe_digits
// decimal digit extractor, one place per cycle from the top, keeps the
// five leading significant digits and the significant digit count
// ----------------------------------------------------------------------------
module lmtfe_digits
   import lmtfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [62:0]   value,
   input  logic          ack,
   output logic          busy,
   output digit_res_type res
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [62:0]   rem_ff, rem_in;
   logic [4:0]    place_ff, place_in;
   logic [4:0]    count_ff, count_in;
   glyph_row_type top_ff, top_in;

   logic [62:0]      pw;
   logic [9:1][62:0] mult;
   logic [9:1][63:0] diff;
   logic [3:0]       digit;
   logic [62:0]      rem_next;

   // multiples of the current place value, compared in parallel
   assign pw = pow10(place_ff);
   for (genvar j = 1; j <= 9; j++) begin : g_mult
      assign mult[j] = 63'(pw * 63'(j));
      assign diff[j] = {1'b0, rem_ff} - {1'b0, mult[j]};
   end

   // digit is the largest multiple that fits
   always_comb begin
      digit    = '0;
      rem_next = rem_ff;
      for (int j = 1; j <= 9; j++) begin
         if (!diff[j][63]) begin
            digit    = 4'(j);
            rem_next = diff[j][62:0];
         end
      end
   end

   // sequencing and leading digit capture
   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff && !ack;
      rem_in   = rem_ff;
      place_in = place_ff;
      count_in = count_ff;
      top_in   = top_ff;
      if (start) begin
         busy_in  = 1'b1;
         rem_in   = value;
         place_in = 5'(DecPlaces - 1);
         count_in = '0;
      end else if (busy_ff) begin
         rem_in   = rem_next;
         place_in = place_ff - 5'd1;
         // the ones place always counts so that zero shows as one digit
         if (count_ff != '0 || digit != '0 || place_ff == '0) begin
            if (count_ff < 5'(TextFields)) begin
               top_in[count_ff[2:0]] = digit;
            end
            count_in = count_ff + 5'd1;
         end
         if (place_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      place_ff <= place_in;
      count_ff <= count_in;
      top_ff   <= top_in;
   end

   assign busy       = busy_ff;
   assign res.done   = done_ff;
   assign res.count  = count_ff;
   assign res.digits = top_ff;

endmodule

// ===== hw/rtl/lmtfe_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtfe_lane
// one character lane: places a glyph at its column of the centred text
// ----------------------------------------------------------------------------
module lmtfe_lane
   import lmtfe_pkg::*;
#(
   parameter int LANE = 0
)
(
   input  logic       active,
   input  logic [3:0] glyph,
   input  logic [2:0] text_len,
   output frame_type  rows
);

   localparam logic [4:0] LaneOffset = 5'(6 * LANE);

   glyph_type  cols;
   logic [4:0] base;

   assign cols = glyph_cols(glyph);
   assign base = text_x0(text_len) + LaneOffset;

   // row r: the five glyph bits shifted to the lane column, msb is column 0
   always_comb begin
      for (int r = 0; r < 8; r++) begin
         rows[r] = active ? ({cols[0][r], cols[1][r], cols[2][r], cols[3][r],
                              cols[4][r], 27'd0} >> base) : '0;
      end
   end

endmodule

// ===== hw/rtl/lmtfe_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtfe_emit
// register word sequencer: intensity words, then row words per module,
// highest module first, one word per cycle while rsp_tready allows, into an output register
// ----------------------------------------------------------------------------
`include "led_matrix_text_frame_encoder_macros.svh"
module lmtfe_emit
   import lmtfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   output logic                load_ready,
   input  frame_type           frame,
   input  emit_job_type        job,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,  // register_address, register_data
   output logic                rsp_tuser,  // latch_end
   output logic                rsp_tlast
);

   logic       active_ff, active_in;
   logic       intens_ff, intens_in;
   logic [2:0] row_ff, row_in;
   logic [1:0] mod_ff, mod_in;
   logic [2:0] mods_ff;
   logic [3:0] bright_ff;
   frame_type  frame_ff;

   logic       valid_ff, valid_in;
   logic [3:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic       latch_ff, latch_in;
   logic       last_ff, last_in;

   logic       adv;
   logic       load;
   logic [1:0] top_mod;
   logic [4:0] byte_hi;

   assign load_ready = !active_ff;
   assign load       = load_valid && load_ready;
   assign adv        = active_ff && (!valid_ff || rsp_tready);
   assign top_mod    = 2'(mods_ff - 3'd1);
   assign byte_hi    = 5'd31 - {mod_ff, 3'd0};

   // next word and counter advance
   always_comb begin
      active_in = active_ff;
      intens_in = intens_ff;
      row_in    = row_ff;
      mod_in    = mod_ff;
      valid_in  = valid_ff && !rsp_tready;
      addr_in   = addr_ff;
      data_in   = data_ff;
      latch_in  = latch_ff;
      last_in   = last_ff;
      if (load) begin
         active_in = 1'b1;
         intens_in = 1'b1;
         row_in    = '0;
         mod_in    = '0;
      end else if (adv) begin
         valid_in = 1'b1;
         if (intens_ff) begin
            addr_in  = RegIntensity;
            data_in  = {4'd0, bright_ff};
            latch_in = (mod_ff == top_mod);
            last_in  = 1'b0;
            if (mod_ff == top_mod) begin
               intens_in = 1'b0;
               mod_in    = top_mod;
            end else begin
               mod_in = mod_ff + 2'd1;
            end
         end else begin
            addr_in  = {1'b0, row_ff} + 4'd1;
            data_in  = frame_ff[row_ff][byte_hi -: 8];
            latch_in = (mod_ff == '0);
            last_in  = (mod_ff == '0) && (row_ff == 3'd7);
            if (mod_ff == '0) begin
               mod_in = top_mod;
               if (row_ff == 3'd7) begin
                  active_in = 1'b0;
               end else begin
                  row_in = row_ff + 3'd1;
               end
            end else begin
               mod_in = mod_ff - 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      intens_ff <= intens_in;
      row_ff    <= row_in;
      mod_ff    <= mod_in;
      addr_ff   <= addr_in;
      data_ff   <= data_in;
      latch_ff  <= latch_in;
      last_ff   <= last_in;
      if (load) begin
         frame_ff  <= frame;
         mods_ff   <= job.mods;
         bright_ff <= job.bright;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, data_ff, addr_ff};
   assign rsp_tuser  = latch_ff;
   assign rsp_tlast  = last_ff;

   // checks
   `LMTFE_ASSERT(a_last_latched, valid_ff && last_ff |-> latch_ff)
   `LMTFE_ASSERT(a_load_starts, load |=> active_ff && intens_ff)
   `LMTFE_ASSERT(a_mod_bound, active_ff |-> {1'b0, mod_ff} < mods_ff)
   `LMTFE_NEVER(a_bad_addr, valid_ff && addr_ff != RegIntensity && (addr_ff == 4'd0 || addr_ff > 4'd8))

endmodule

// ===== hw/rtl/led_matrix_text_frame_encoder.sv =====
`timescale 1ns / 1ps
// path: a text item or negative number passes the text stage register, then the
//   sequencer's active state and output register; a non-negative number first runs
//   the decimal place scan in lmtfe_digits, which overlaps the current item's words
// throughput: set by the one word per cycle sequencer while rsp_tready allows, or by the
//   decimal place scan of a non-negative number; an intensity word and eight row words per module for each item
// reset: module_count 4, start and current brightness 0, all stages empty
// ----------------------------------------------------------------------------
// led_matrix_text_frame_encoder
// renders text or a compacted number centred on a 32x8 frame with character
// lanes and emits intensity and row register words for the chained modules
// ----------------------------------------------------------------------------
module led_matrix_text_frame_encoder
   import lmtfe_pkg::*;
#(
   parameter int MAX_MODULES = 4,
   parameter int MAX_CHARS   = 5
)
(
   input  logic                clock,
   input  logic                reset,
   // number_value, text_length, text_char0..4, intensity level
   input  logic [ReqDataW-1:0] req_tdata,
   // value_kind, brightness_given
   input  logic [1:0]          req_tuser,
   input  logic                req_tvalid,
   output logic                req_tready,
   // register_address, register_data
   output logic [RspDataW-1:0] rsp_tdata,
   // latch_end
   output logic                rsp_tuser,
   output logic                rsp_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [7:0]          csr_data
);

   logic [2:0]    mc_ff;
   logic [3:0]    cur_ff;
   logic [3:0]    pend_bright_ff;
   logic          s1_valid_ff;
   glyph_row_type s1_glyph_ff;
   logic [2:0]    s1_len_ff;
   logic [3:0]    s1_bright_ff;

   logic          acc;
   logic          csr_wr;
   logic          dig_busy;
   digit_res_type dig_res;
   logic          dig_start;
   logic          dig_ack;
   logic          emit_ready;
   logic          emit_take;
   logic [3:0]    item_bright;
   logic [2:0]    want;
   logic          stop;
   glyph_row_type txt_glyph, num_glyph;
   logic [2:0]    txt_len, num_len;
   logic [4:0]    nb;
   logic [2:0]    mods;
   frame_type     frame;
   frame_type     lane_rows [MAX_CHARS];
   emit_job_type  job;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign req_tready = !dig_busy && !dig_res.done && !s1_valid_ff;
   assign acc       = req_tvalid && req_tready;
   assign dig_start = acc && req_tuser[0] && !req_tdata[63];
   assign dig_ack   = dig_res.done && !s1_valid_ff;
   assign emit_take = s1_valid_ff && emit_ready;
   assign item_bright = req_tuser[1] ? req_tdata[110:107] : cur_ff;

   // text item: lookup glyphs, stop at a zero code, cap the length; a negative number shows as four dashes
   always_comb begin
      want    = (req_tdata[66:64] > 3'(TextFields)) ? 3'(TextFields) : req_tdata[66:64];
      txt_len = '0;
      stop    = 1'b0;
      for (int i = 0; i < TextFields; i++) begin
         txt_glyph[i] = glyph_index(req_tdata[67 + 8*i +: 8]);
         if (3'(i) < want && !stop) begin
            if (req_tdata[67 + 8*i +: 8] == 8'd0) begin
               stop = 1'b1;
            end else begin
               txt_len = 3'(i + 1);
            end
         end
      end
      if (req_tdata[63] && req_tuser[0]) begin
         txt_glyph = {GlyphBlank, GlyphDash, GlyphDash, GlyphDash, GlyphDash};
         txt_len   = 3'd4;
      end
      if (txt_len > 3'(MAX_CHARS)) begin
         txt_len = 3'(MAX_CHARS);
      end
   end

   // number text from the leading digits and the significant digit count
   always_comb begin
      num_glyph = dig_res.digits;
      num_len   = 3'd5;
      nb        = dig_res.count - 5'd9;
      if (dig_res.count <= 5'd5) begin
         num_len = dig_res.count[2:0];
      end else if (dig_res.count == 5'd6) begin
         num_glyph[3] = GlyphKilo;
         num_len      = 3'd4;
      end else if (dig_res.count == 5'd7) begin
         num_glyph[1] = GlyphDot;
         num_glyph[2] = dig_res.digits[1];
         num_glyph[3] = GlyphMega;
         num_len      = 3'd4;
      end else if (dig_res.count == 5'd8) begin
         num_glyph[2] = GlyphMega;
         num_len      = 3'd3;
      end else if (dig_res.count == 5'd9) begin
         num_glyph[3] = GlyphMega;
         num_len      = 3'd4;
      end else if (dig_res.count <= 5'd13) begin
         num_glyph[nb[2:0]] = GlyphBil;
         num_len            = nb[2:0] + 3'd1;
      end
      if (num_len > 3'(MAX_CHARS)) begin
         num_len = 3'(MAX_CHARS);
      end
   end

   // config registers and running brightness
   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff  <= 3'd4;
         cur_ff <= '0;
      end else begin
         if (csr_wr && csr_index == CsrModuleCount) begin
            mc_ff <= csr_data[2:0];
         end
         if (csr_wr && csr_index == CsrStartBright) begin
            cur_ff <= csr_data[3:0];
         end else if (acc) begin
            cur_ff <= item_bright;
         end
      end
   end

   // text stage ahead of the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (acc && !dig_start) begin
         s1_valid_ff <= 1'b1;
      end else if (dig_ack) begin
         s1_valid_ff <= 1'b1;
      end else if (emit_take) begin
         s1_valid_ff <= 1'b0;
      end
      if (dig_start) begin
         pend_bright_ff <= item_bright;
      end
      if (acc && !dig_start) begin
         s1_glyph_ff  <= txt_glyph;
         s1_len_ff    <= txt_len;
         s1_bright_ff <= item_bright;
      end else if (dig_ack) begin
         s1_glyph_ff  <= num_glyph;
         s1_len_ff    <= num_len;
         s1_bright_ff <= pend_bright_ff;
      end
   end

   lmtfe_digits u_digits (
      .clock (clock),
      .reset (reset),
      .start (dig_start),
      .value (req_tdata[62:0]),
      .ack   (dig_ack),
      .busy  (dig_busy),
      .res   (dig_res)
   );

   // character lanes
   for (genvar i = 0; i < MAX_CHARS; i++) begin : g_lane
      lmtfe_lane #(.LANE(i)) u_lane (
         .active   (3'(i) < s1_len_ff),
         .glyph    (s1_glyph_ff[i]),
         .text_len (s1_len_ff),
         .rows     (lane_rows[i])
      );
   end

   // merge lanes into one frame
   always_comb begin
      frame = '0;
      for (int i = 0; i < MAX_CHARS; i++) begin
         frame = frame | lane_rows[i];
      end
   end

   assign mods = (mc_ff == '0 || mc_ff > 3'(MAX_MODULES)) ? 3'(MAX_MODULES) : mc_ff;
   assign job.mods   = mods;
   assign job.bright = s1_bright_ff;

   lmtfe_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff),
      .load_ready (emit_ready),
      .frame      (frame),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
